### sv/tlgs_pkg.sv
package tlgs_pkg;

    localparam int GOL_ROWS = 32;
    localparam int GOL_COLS = 32;
    localparam int GEN_W    = 32;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    // Glider start pattern, bit c is column c.
    function automatic logic [2:0] start_bits(input int unsigned r);
        logic [2:0] bits;
        case (r)
            0:       bits = 3'b010;
            1:       bits = 3'b100;
            2:       bits = 3'b111;
            default: bits = 3'b000;
        endcase
        return bits;
    endfunction

endpackage

### sv/toroidal_life_grid_stepper_unit.sv
// Cell write, cell read and restore: the row is read in ST_RD_ISSUE and the result
// is registered from ST_RD_DATA; an input transfer is taken only in ST_IDLE.
// Advance: the row RAM is swept once, one row per cycle through a three-row window
// and a shared row update unit. A new input transfer is taken while a finished
// result still waits.
// Reset (aresetn low, synchronous) loads the glider start pattern through
// per-row valid bits and clears the generation counter; no clearing pass.
module toroidal_life_grid_stepper_unit #(
    parameter int ROWS = tlgs_pkg::GOL_ROWS,
    parameter int COLS = tlgs_pkg::GOL_COLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action[1:0], row[6:2], col[11:7], cell_in[12], zero fill [15:13]
    input  logic [tlgs_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_out[0], generation_count[32:1], zero fill [39:33]
    output logic [tlgs_pkg::M_DATA_W-1:0] m_tdata
);

    import tlgs_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int SW = $clog2(ROWS + 3);

    state_t            state_reg, state_next;
    action_t           action_reg;
    logic [RW-1:0]     row_idx_reg;
    logic [CW-1:0]     col_idx_reg;
    logic              inside_reg;
    logic              cell_in_reg;
    logic [GEN_W-1:0]  gen_count_reg;
    logic [SW-1:0]     step_reg;
    logic [ROWS-1:0]   row_valid_reg;
    logic [COLS-1:0]   prev_reg, cur_reg, row0_reg;
    logic [RW-1:0]     rd_row_reg;
    logic              rd_valid_reg;
    logic              m_tvalid_reg;
    logic              m_cell_reg;
    logic [GEN_W-1:0]  m_count_reg;

    action_t           in_action;
    logic [4:0]        in_row, in_col;
    logic [RW+4:0]     in_row_wide;
    logic [CW+4:0]     in_col_wide;
    logic              in_inside;
    logic              accept;
    logic              out_busy;

    logic              ram_we, ram_rd_en;
    logic [RW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [COLS-1:0]   ram_wr_data, ram_q;
    logic [COLS-1:0]   eff_row, mod_row, next_row, new_row;
    logic [SW-1:0]     step_m1, step_m3;
    logic              arrive;

    assign in_action   = action_t'(s_tdata[1:0]);
    assign in_row      = s_tdata[6:2];
    assign in_col      = s_tdata[11:7];
    assign in_row_wide = (RW + 5)'(in_row);
    assign in_col_wide = (CW + 5)'(in_col);
    assign in_inside   = ({27'd0, in_row} < 32'(ROWS)) && ({27'd0, in_col} < 32'(COLS));

    assign accept   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign step_m1  = step_reg - SW'(1);
    assign step_m3  = step_reg - SW'(3);
    assign arrive   = (step_reg >= SW'(1)) && (step_reg <= SW'(ROWS + 1));

    always_comb begin
        eff_row = '0;
        eff_row[2:0] = start_bits(32'(rd_row_reg));
        if (rd_valid_reg) begin
            eff_row = ram_q;
        end
        mod_row = eff_row;
        mod_row[col_idx_reg] = cell_in_reg;
    end

    assign next_row = (step_reg == SW'(ROWS + 2)) ? row0_reg : eff_row;

    tlgs_row_unit #(
        .COLS(COLS)
    ) u_row_unit (
        .prev_row(prev_reg),
        .cur_row (cur_reg),
        .next_row(next_row),
        .new_row (new_row)
    );

    tlgs_ram #(
        .WIDTH(COLS),
        .DEPTH(ROWS)
    ) u_grid_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (in_action == ACT_ADVANCE) ? ST_ADVANCE : ST_RD_ISSUE;
                end
            end
            ST_ADVANCE: begin
                if (step_reg == SW'(ROWS + 2)) begin
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (!out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_we      = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = new_row;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ADVANCE: begin
                if (step_reg <= SW'(ROWS)) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = (step_reg == '0) ? RW'(ROWS - 1) : step_m1[RW-1:0];
                end
                if (step_reg >= SW'(3)) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = step_m3[RW-1:0];
                    ram_wr_data = new_row;
                end
            end
            ST_RD_ISSUE: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = row_idx_reg;
            end
            ST_RD_DATA: begin
                if (!out_busy && (action_reg == ACT_WRITE) && inside_reg) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = row_idx_reg;
                    ram_wr_data = mod_row;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gen_count_reg <= '0;
            row_valid_reg <= '0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                step_reg <= '0;
                if (in_action == ACT_RESTORE) begin
                    row_valid_reg <= '0;
                    gen_count_reg <= '0;
                end
            end
            if (state_reg == ST_ADVANCE) begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(ROWS + 2)) begin
                    gen_count_reg <= gen_count_reg + GEN_W'(1);
                end
            end
            if (ram_we) begin
                row_valid_reg[ram_wr_addr] <= 1'b1;
            end
            if ((state_reg == ST_RD_DATA) && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg  <= in_action;
            row_idx_reg <= in_row_wide[RW-1:0];
            col_idx_reg <= in_col_wide[CW-1:0];
            inside_reg  <= in_inside;
            cell_in_reg <= s_tdata[12];
        end
        if (ram_rd_en) begin
            rd_row_reg   <= ram_rd_addr;
            rd_valid_reg <= row_valid_reg[ram_rd_addr];
        end
        if ((state_reg == ST_ADVANCE) && arrive) begin
            prev_reg <= cur_reg;
            cur_reg  <= eff_row;
            if (step_reg == SW'(2)) begin
                row0_reg <= eff_row;
            end
        end
        if ((state_reg == ST_RD_DATA) && !out_busy) begin
            m_count_reg <= gen_count_reg;
            if (!inside_reg) begin
                m_cell_reg <= 1'b0;
            end else if (action_reg == ACT_WRITE) begin
                m_cell_reg <= cell_in_reg;
            end else begin
                m_cell_reg <= eff_row[col_idx_reg];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_cell_reg};

`ifndef NO_ASSERTIONS
    a_gen_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_count_reg != $past(gen_count_reg)) |->
        (gen_count_reg == $past(gen_count_reg) + GEN_W'(1) || gen_count_reg == '0))
        else $error("generation counter moved by other than one or a restore");

    a_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_action == ACT_RESTORE)) |=>
        (row_valid_reg == '0 && gen_count_reg == '0))
        else $error("restore did not reload the start pattern");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_DATA && m_tvalid_reg && !m_tready) |=>
        (state_reg == ST_RD_DATA))
        else $error("result produced while the output register was occupied");

    a_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("row RAM read and write at the same address");
`endif

endmodule

### sv/tlgs_ram.sv
module tlgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                    wr_data,
    input  logic                                rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/tlgs_row_unit.sv
module tlgs_row_unit #(
    parameter int COLS = 32
) (
    input  logic [COLS-1:0] prev_row,
    input  logic [COLS-1:0] cur_row,
    input  logic [COLS-1:0] next_row,
    output logic [COLS-1:0] new_row
);

    for (genvar c = 0; c < COLS; c++) begin : g_col
        localparam int LF = (c + COLS - 1) % COLS;
        localparam int RT = (c + 1) % COLS;
        logic [3:0] n;

        assign n = 4'(prev_row[LF]) + 4'(prev_row[c]) + 4'(prev_row[RT])
                 + 4'(cur_row[LF]) + 4'(cur_row[RT])
                 + 4'(next_row[LF]) + 4'(next_row[c]) + 4'(next_row[RT]);

        assign new_row[c] = (n == 4'd3) || (cur_row[c] && (n == 4'd2));
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import tlgs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 600;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } cell_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    logic [GOL_COLS-1:0]   life_grid [GOL_ROWS];
    logic [GEN_W-1:0]      gen_count;
    cell_result_t          pending_cells [$];

    int s_idle_pct   = 0;
    int r_idle_pct   = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int action_hits [4] = '{0, 0, 0, 0};

    toroidal_life_grid_stepper_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void load_glider();
        for (int i = 0; i < GOL_ROWS; i++) begin
            life_grid[i] = '0;
        end
        life_grid[0][1]   = 1'b1;
        life_grid[1][2]   = 1'b1;
        life_grid[2][2:0] = 3'b111;
        gen_count = '0;
    endfunction

    function automatic void step_generation();
        logic [GOL_COLS-1:0] next_rows [GOL_ROWS];
        int n;
        for (int r = 0; r < GOL_ROWS; r++) begin
            for (int c = 0; c < GOL_COLS; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n = n + life_grid[(r + dr + GOL_ROWS) % GOL_ROWS]
                                             [(c + dc + GOL_COLS) % GOL_COLS];
                        end
                    end
                end
                if (life_grid[r][c]) begin
                    next_rows[r][c] = (n == 2 || n == 3);
                end else begin
                    next_rows[r][c] = (n == 3);
                end
            end
        end
        life_grid = next_rows;
        gen_count = gen_count + 1'b1;
    endfunction

    function automatic cell_result_t predict_cell_result(action_t act, logic [4:0] r,
                                                         logic [4:0] c, logic v);
        cell_result_t res;
        case (act)
            ACT_WRITE: begin
                life_grid[r][c] = v;
            end
            ACT_ADVANCE: begin
                step_generation();
            end
            ACT_RESTORE: begin
                load_glider();
            end
            default: begin
            end
        endcase
        res.alive = life_grid[r][c];
        res.gen   = gen_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t: %s, got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_cmd(action_t act, logic [4:0] r, logic [4:0] c, logic v);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, v, c, r, act};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_cells.push_back(predict_cell_result(act, r, c, v));
        action_hits[act]++;
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cells.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_cells.size() == 0) begin
                report_mismatch("result transfer with nothing expected", 64'(m_tdata), '0);
            end else begin
                want = pending_cells.pop_front();
                if (m_tdata[0] !== want.alive) begin
                    report_mismatch("cell_out", 64'(m_tdata[0]), 64'(want.alive));
                end
                if (m_tdata[GEN_W:1] !== want.gen) begin
                    report_mismatch("generation_count", 64'(m_tdata[GEN_W:1]),
                                    64'(want.gen));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d results outstanding.",
                     pending_cells.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_power_on_glider();
        send_cmd(ACT_READ, 5'd0, 5'd1, 1'b1);
        send_cmd(ACT_READ, 5'd1, 5'd1, 1'b0);
        send_cmd(ACT_READ, 5'd2, 5'd2, 1'b1);
    endtask

    task automatic test_glider_generations();
        send_cmd(ACT_ADVANCE, 5'd1, 5'd0, 1'b0);
        send_cmd(ACT_ADVANCE, 5'd2, 5'd1, 1'b1);
        send_cmd(ACT_READ, 5'd1, 5'd2, 1'b0);
        send_cmd(ACT_READ, 5'd2, 5'd1, 1'b1);
    endtask

    // A blinker split across the row and column seams, beside the glider.
    task automatic test_wrapped_edges();
        send_cmd(ACT_RESTORE, 5'd31, 5'd31, 1'b0);
        send_cmd(ACT_WRITE, 5'd31, 5'd31, 1'b1);
        send_cmd(ACT_WRITE, 5'd31, 5'd0, 1'b1);
        send_cmd(ACT_WRITE, 5'd31, 5'd1, 1'b1);
        send_cmd(ACT_WRITE, 5'd0, 5'd1, 1'b0);
        send_cmd(ACT_ADVANCE, 5'd0, 5'd0, 1'b1);
        send_cmd(ACT_READ, 5'd0, 5'd0, 1'b0);
        send_cmd(ACT_READ, 5'd30, 5'd0, 1'b1);
        send_cmd(ACT_READ, 5'd31, 5'd31, 1'b0);
    endtask

    task automatic test_cell_extremes();
        send_cmd(ACT_WRITE, 5'd31, 5'd31, 1'b0);
        send_cmd(ACT_READ, 5'd31, 5'd31, 1'b1);
        send_cmd(ACT_WRITE, 5'd0, 5'd0, 1'b1);
        send_cmd(ACT_READ, 5'd0, 5'd0, 1'b0);
        send_cmd(ACT_RESTORE, 5'd0, 5'd0, 1'b1);
        send_cmd(ACT_READ, 5'd0, 5'd0, 1'b0);
    endtask

    task automatic test_random_traffic(int count);
        int         start;
        int         pick;
        int         size;
        int         density;
        logic [4:0] r0;
        logic [4:0] c0;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            r0   = 5'($urandom_range(31));
            c0   = 5'($urandom_range(31));
            if (pick < 55) begin
                // Seed a random patch, then let it evolve and probe around it.
                size    = $urandom_range(3, 5);
                density = $urandom_range(25, 70);
                for (int i = 0; i < size; i++) begin
                    for (int j = 0; j < size; j++) begin
                        send_cmd(ACT_WRITE, 5'(r0 + i), 5'(c0 + j),
                                 $urandom_range(99) < density);
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    send_cmd(ACT_ADVANCE, 5'(r0 + $urandom_range(size + 1) - 1),
                             5'(c0 + $urandom_range(size + 1) - 1),
                             1'($urandom_range(1)));
                    repeat (2) begin
                        send_cmd(ACT_READ, 5'(r0 + $urandom_range(size + 1) - 1),
                                 5'(c0 + $urandom_range(size + 1) - 1),
                                 1'($urandom_range(1)));
                    end
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    send_cmd(action_t'(2'($urandom_range(3))), 5'($urandom_range(31)),
                             5'($urandom_range(31)), 1'($urandom_range(1)));
                end
            end else if (pick < 95) begin
                repeat ($urandom_range(10, 40)) begin
                    send_cmd(ACT_ADVANCE, 5'($urandom_range(31)), 5'($urandom_range(31)),
                             1'($urandom_range(1)));
                end
            end else begin
                send_cmd(ACT_RESTORE, r0, c0, 1'($urandom_range(1)));
                repeat (3) begin
                    send_cmd(ACT_READ, 5'($urandom_range(3)), 5'($urandom_range(3)),
                             1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic test_drained_pause();
        wait_results_drained();
        repeat ($urandom_range(1, 20)) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        load_glider();
        repeat (3) begin
            @(posedge aclk);
        end
        aresetn <= 1'b1;
        @(posedge aclk);

        s_idle_pct = 17;
        r_idle_pct = 69;
        test_power_on_glider();
        test_glider_generations();
        test_wrapped_edges();
        test_cell_extremes();
        test_random_traffic(PHASE_ITEMS);
        test_drained_pause();

        s_idle_pct = 69;
        r_idle_pct = 17;
        test_random_traffic(PHASE_ITEMS);
        test_drained_pause();

        s_idle_pct = 0;
        r_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        wait_results_drained();
        repeat (TAIL_CYCLES) begin
            @(posedge aclk);
        end

        $display("Sent %0d transfers: %0d writes, %0d reads, %0d advances, %0d restores.",
                 items_sent, action_hits[ACT_WRITE], action_hits[ACT_READ],
                 action_hits[ACT_ADVANCE], action_hits[ACT_RESTORE]);
        $display("Compared %0d results over %0d cycles, %0d mismatches.",
                 results_seen, cycle_count, err_count);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
